FILE: rtl/core/svpwm_pkg.sv
`default_nettype none
package svpwm_pkg;

  localparam int CONST_W   = 19;
  localparam int FRAC_BITS = 16;
  localparam int CAP_LOG   = 47;
  localparam int CAP_W     = 48;

  localparam logic signed [CONST_W-1:0] SQRT3_Q16      = 19'sd113512;
  localparam logic signed [CONST_W-1:0] HALF_SQRT3_Q16 = 19'sd56756;
  localparam logic signed [CONST_W-1:0] ONE_HALF3_Q16  = 19'sd98304;

  localparam logic [2:0] SECTOR_NONE = 3'd0;
  localparam logic [2:0] SECTOR_1    = 3'd1;
  localparam logic [2:0] SECTOR_2    = 3'd2;
  localparam logic [2:0] SECTOR_3    = 3'd3;
  localparam logic [2:0] SECTOR_4    = 3'd4;
  localparam logic [2:0] SECTOR_5    = 3'd5;
  localparam logic [2:0] SECTOR_6    = 3'd6;
  localparam logic [2:0] SECTOR_ALL  = 3'd7;

  typedef struct packed {
    logic [2:0] sector;
    logic       fault;
    logic       over;
  } svpwm_ctl_t;

  function automatic logic sector_active(logic [2:0] s);
    return (s != SECTOR_NONE) && (s != SECTOR_ALL);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/svpwm_div.sv
`default_nettype none
module svpwm_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld   [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vin;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;
    logic [NUM_W-1:0] quo_next;

    if (i == 0) begin : g_first
      assign vin    = in_valid;
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
      assign tag_in = tag;
    end else begin : g_next
      assign vin    = vld[i-1];
      assign num_in = num_q[i-1];
      assign quo_in = quo_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign rem_sh   = {rem_in, num_in[NUM_W-1-i]};
    assign rem_sub  = rem_sh - {1'b0, den_in};
    assign ge       = rem_sh >= {1'b0, den_in};
    assign quo_next = quo_in | (NUM_W'(ge) << (NUM_W-1-i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      num_q[i] <= num_in;
      den_q[i] <= den_in;
      tag_q[i] <= tag_in;
      rem_q[i] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q[i] <= quo_next;
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = quo_q[NUM_W-1];
  assign out_tag   = tag_q[NUM_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/svpwm_front.sv
`default_nettype none
module svpwm_front #(
  parameter int VOLT_WIDTH = 16,
  parameter int TICK_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [VOLT_WIDTH-1:0]         v_alpha,
  input  logic signed [VOLT_WIDTH-1:0]         v_beta,
  input  logic [VOLT_WIDTH-1:0]                bus_voltage,
  input  logic [TICK_WIDTH-1:0]                period,
  output logic                                 out_valid,
  output logic [VOLT_WIDTH+TICK_WIDTH:0]       num_x,
  output logic [VOLT_WIDTH+TICK_WIDTH:0]       num_y,
  output logic [VOLT_WIDTH+TICK_WIDTH:0]       num_z,
  output logic [VOLT_WIDTH-1:0]                den,
  output logic [2:0]                           neg,
  output svpwm_pkg::svpwm_ctl_t                ctl
);
  import svpwm_pkg::*;

  localparam int PW   = VOLT_WIDTH + CONST_W;
  localparam int NW   = VOLT_WIDTH + 17;
  localparam int MP_W = NW + TICK_WIDTH;

  logic                         v1;
  logic signed [VOLT_WIDTH-1:0] va1;
  logic signed [VOLT_WIDTH-1:0] vb1;
  logic [VOLT_WIDTH-1:0]        u1;

  logic                         v2;
  logic signed [PW-1:0]         px2;
  logic signed [PW-1:0]         pav2;
  logic signed [PW-1:0]         pa2;
  logic signed [PW-1:0]         pb2;
  logic signed [PW-1:0]         vb2;
  logic                         pos2;
  logic [VOLT_WIDTH-1:0]        u2;

  logic                         v3;
  logic signed [PW-1:0]         x3;
  logic signed [PW-1:0]         y3;
  logic signed [PW-1:0]         z3;
  svpwm_ctl_t                   ctl3;
  logic [VOLT_WIDTH-1:0]        u3;

  logic                         v4;
  logic [NW-1:0]                mx4;
  logic [NW-1:0]                my4;
  logic [NW-1:0]                mz4;
  logic [2:0]                   neg4;
  svpwm_ctl_t                   ctl4;
  logic [VOLT_WIDTH-1:0]        u4;

  logic signed [PW-1:0]         test_a;
  logic signed [PW-1:0]         test_b;
  logic [MP_W-1:0]              prod_x;
  logic [MP_W-1:0]              prod_y;
  logic [MP_W-1:0]              prod_z;

  assign test_a = pav2 - vb2;
  assign test_b = -pav2 - vb2;
  assign prod_x = MP_W'(mx4) * MP_W'(period);
  assign prod_y = MP_W'(my4) * MP_W'(period);
  assign prod_z = MP_W'(mz4) * MP_W'(period);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    va1 <= v_alpha;
    vb1 <= v_beta;
    u1  <= bus_voltage;

    px2  <= PW'(vb1) * PW'(SQRT3_Q16);
    pav2 <= PW'(va1) * PW'(SQRT3_Q16);
    pa2  <= PW'(va1) * PW'(ONE_HALF3_Q16);
    pb2  <= PW'(vb1) * PW'(HALF_SQRT3_Q16);
    vb2  <= PW'(vb1) <<< FRAC_BITS;
    pos2 <= !vb1[VOLT_WIDTH-1] && (vb1 != '0);
    u2   <= u1;

    x3          <= px2;
    y3          <= pa2 + pb2;
    z3          <= pb2 - pa2;
    ctl3.sector <= {!test_b[PW-1] && (test_b != '0), !test_a[PW-1] && (test_a != '0), pos2};
    ctl3.fault  <= (u2 == '0);
    ctl3.over   <= 1'b0;
    u3          <= u2;

    mx4  <= NW'(x3[PW-1] ? -x3 : x3);
    my4  <= NW'(y3[PW-1] ? -y3 : y3);
    mz4  <= NW'(z3[PW-1] ? -z3 : z3);
    neg4 <= {z3[PW-1], y3[PW-1], x3[PW-1]};
    ctl4 <= ctl3;
    u4   <= u3;

    num_x <= prod_x[MP_W-1:FRAC_BITS];
    num_y <= prod_y[MP_W-1:FRAC_BITS];
    num_z <= prod_z[MP_W-1:FRAC_BITS];
    neg   <= neg4;
    ctl   <= ctl4;
    den   <= u4;
  end

endmodule
`default_nettype wire

FILE: rtl/core/svpwm_mid.sv
`default_nettype none
module svpwm_mid #(
  parameter int QUO_W      = 33,
  parameter int TIME_W     = 33,
  parameter int TICK_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [QUO_W-1:0]                 q_x,
  input  logic [QUO_W-1:0]                 q_y,
  input  logic [QUO_W-1:0]                 q_z,
  input  logic [2:0]                       neg,
  input  svpwm_pkg::svpwm_ctl_t            ctl,
  input  logic [TICK_WIDTH-1:0]            period,
  output logic                             out_valid,
  output logic [TIME_W+TICK_WIDTH-1:0]     num_1,
  output logic [TIME_W+TICK_WIDTH-1:0]     num_2,
  output logic [TIME_W:0]                  den,
  output logic signed [TIME_W:0]           t_1,
  output logic signed [TIME_W:0]           t_2,
  output logic [1:0]                       neg_out,
  output svpwm_pkg::svpwm_ctl_t            ctl_out
);
  import svpwm_pkg::*;

  localparam int SW   = (QUO_W > CAP_W) ? QUO_W : CAP_W;
  localparam int MP_W = TIME_W + TICK_WIDTH;

  function automatic logic signed [TIME_W:0] signed_time(logic [QUO_W-1:0] q, logic n);
    logic [SW-1:0]            e;
    logic signed [TIME_W:0]   s;
    e = SW'(q);
    if (e > (SW'(1) << CAP_LOG)) begin
      e = SW'(1) << CAP_LOG;
    end
    s = $signed({1'b0, TIME_W'(e)});
    return n ? -s : s;
  endfunction

  logic                     v1, v2, v3, v4;
  logic signed [TIME_W:0]   x1, y1, z1;
  svpwm_ctl_t               ctl1, ctl2, ctl3, ctl4;
  logic signed [TIME_W:0]   t1_2, t2_2, t1_3, t2_3, t1_4, t2_4;
  logic signed [TIME_W+1:0] sum3;
  logic signed [TIME_W+1:0] sum4;
  logic [TIME_W-1:0]        a1_4, a2_4;
  logic [1:0]               n4;
  logic signed [TIME_W:0]   t1_next, t2_next;
  logic signed [TIME_W+1:0] sum_next;
  logic signed [TIME_W+1:0] per_s;
  logic                     over_next;

  always_comb begin
    unique case (ctl1.sector)
      SECTOR_1: begin
        t1_next = z1;
        t2_next = y1;
      end
      SECTOR_2: begin
        t1_next = y1;
        t2_next = -x1;
      end
      SECTOR_3: begin
        t1_next = -z1;
        t2_next = x1;
      end
      SECTOR_4: begin
        t1_next = -x1;
        t2_next = z1;
      end
      SECTOR_5: begin
        t1_next = x1;
        t2_next = -y1;
      end
      SECTOR_6: begin
        t1_next = -y1;
        t2_next = -z1;
      end
      SECTOR_NONE, SECTOR_ALL: begin
        t1_next = '0;
        t2_next = '0;
      end
    endcase
  end

  assign sum_next  = (TIME_W+2)'(t1_2) + (TIME_W+2)'(t2_2);
  assign per_s     = $signed((TIME_W+2)'(period));
  assign over_next = sector_active(ctl2.sector) && !ctl2.fault && (sum_next > per_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= signed_time(q_x, neg[0]);
    y1   <= signed_time(q_y, neg[1]);
    z1   <= signed_time(q_z, neg[2]);
    ctl1 <= ctl;

    t1_2 <= t1_next;
    t2_2 <= t2_next;
    ctl2 <= ctl1;

    t1_3 <= t1_2;
    t2_3 <= t2_2;
    sum3 <= sum_next;
    ctl3 <= '{sector: ctl2.sector, fault: ctl2.fault, over: over_next};

    a1_4 <= TIME_W'(t1_3[TIME_W] ? -t1_3 : t1_3);
    a2_4 <= TIME_W'(t2_3[TIME_W] ? -t2_3 : t2_3);
    n4   <= {t2_3[TIME_W], t1_3[TIME_W]};
    t1_4 <= t1_3;
    t2_4 <= t2_3;
    sum4 <= sum3;
    ctl4 <= ctl3;

    num_1   <= MP_W'(a1_4) * MP_W'(period);
    num_2   <= MP_W'(a2_4) * MP_W'(period);
    den     <= sum4[TIME_W:0];
    t_1     <= t1_4;
    t_2     <= t2_4;
    neg_out <= n4;
    ctl_out <= ctl4;
  end

endmodule
`default_nettype wire

FILE: rtl/core/svpwm_back.sv
`default_nettype none
module svpwm_back #(
  parameter int TIME_W     = 33,
  parameter int TICK_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [TIME_W+TICK_WIDTH-1:0]      q_1,
  input  logic [TIME_W+TICK_WIDTH-1:0]      q_2,
  input  logic signed [TIME_W:0]            t_1,
  input  logic signed [TIME_W:0]            t_2,
  input  logic [1:0]                        neg,
  input  svpwm_pkg::svpwm_ctl_t             ctl,
  input  logic [TICK_WIDTH-1:0]             period,
  output logic                              out_valid,
  output logic [TICK_WIDTH-1:0]             compare_a,
  output logic [TICK_WIDTH-1:0]             compare_b,
  output logic [TICK_WIDTH-1:0]             compare_c,
  output logic [2:0]                        sector_code,
  output logic                              over_modulated,
  output logic                              bus_fault
);
  import svpwm_pkg::*;

  localparam int QUO_W = TIME_W + TICK_WIDTH;
  localparam int SW    = (QUO_W > CAP_W) ? QUO_W : CAP_W;
  localparam int CW    = TIME_W + 4;

  function automatic logic signed [TIME_W:0] signed_time(logic [QUO_W-1:0] q, logic n);
    logic [SW-1:0]          e;
    logic signed [TIME_W:0] s;
    e = SW'(q);
    if (e > (SW'(1) << CAP_LOG)) begin
      e = SW'(1) << CAP_LOG;
    end
    s = $signed({1'b0, TIME_W'(e)});
    return n ? -s : s;
  endfunction

  function automatic logic [TICK_WIDTH-1:0] clamp(logic signed [CW-1:0] v,
                                                  logic [TICK_WIDTH-1:0] hi);
    logic [TICK_WIDTH-1:0] r;
    if (v[CW-1]) begin
      r = '0;
    end else if (v > $signed(CW'(hi))) begin
      r = hi;
    end else begin
      r = TICK_WIDTH'(v);
    end
    return r;
  endfunction

  logic                   v1, v2, v3;
  logic signed [TIME_W:0] t1_1, t2_1;
  svpwm_ctl_t             ctl1, ctl2, ctl3;
  logic signed [CW-1:0]   ta2, h1_2, h2_2;
  logic signed [CW-1:0]   ta3, tb3, tc3;
  logic signed [CW-1:0]   d_next, d_adj, e1, e1_adj, e2, e2_adj;
  logic [TICK_WIDTH-1:0]  half;
  logic [TICK_WIDTH-1:0]  quarter;
  logic [TICK_WIDTH-1:0]  ca_next, cb_next, cc_next;

  assign d_next  = $signed(CW'(period)) - CW'(t1_1) - CW'(t2_1);
  assign d_adj   = d_next[CW-1] ? d_next + CW'(3) : d_next;
  assign e1      = CW'(t1_1);
  assign e1_adj  = e1[CW-1] ? e1 + CW'(1) : e1;
  assign e2      = CW'(t2_1);
  assign e2_adj  = e2[CW-1] ? e2 + CW'(1) : e2;
  assign half    = period >> 1;
  assign quarter = period >> 2;

  always_comb begin
    ca_next = quarter;
    cb_next = quarter;
    cc_next = quarter;
    if (!ctl3.fault) begin
      unique case (ctl3.sector)
        SECTOR_1: begin
          ca_next = clamp(tb3, half);
          cb_next = clamp(ta3, half);
          cc_next = clamp(tc3, half);
        end
        SECTOR_2: begin
          ca_next = clamp(ta3, half);
          cb_next = clamp(tc3, half);
          cc_next = clamp(tb3, half);
        end
        SECTOR_3: begin
          ca_next = clamp(ta3, half);
          cb_next = clamp(tb3, half);
          cc_next = clamp(tc3, half);
        end
        SECTOR_4: begin
          ca_next = clamp(tc3, half);
          cb_next = clamp(tb3, half);
          cc_next = clamp(ta3, half);
        end
        SECTOR_5: begin
          ca_next = clamp(tc3, half);
          cb_next = clamp(ta3, half);
          cc_next = clamp(tb3, half);
        end
        SECTOR_6: begin
          ca_next = clamp(tb3, half);
          cb_next = clamp(tc3, half);
          cc_next = clamp(ta3, half);
        end
        SECTOR_NONE, SECTOR_ALL: begin
          ca_next = quarter;
          cb_next = quarter;
          cc_next = quarter;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    t1_1 <= ctl.over ? signed_time(q_1, neg[0]) : t_1;
    t2_1 <= ctl.over ? signed_time(q_2, neg[1]) : t_2;
    ctl1 <= ctl;

    ta2  <= d_adj >>> 2;
    h1_2 <= e1_adj >>> 1;
    h2_2 <= e2_adj >>> 1;
    ctl2 <= ctl1;

    ta3  <= ta2;
    tb3  <= ta2 + h1_2;
    tc3  <= ta2 + h1_2 + h2_2;
    ctl3 <= ctl2;

    compare_a      <= ca_next;
    compare_b      <= cb_next;
    compare_c      <= cc_next;
    sector_code    <= ctl3.sector;
    over_modulated <= ctl3.over;
    bus_fault      <= ctl3.fault;
  end

endmodule
`default_nettype wire

FILE: rtl/core/svpwm_compare_generator.sv
`default_nettype none
// Space-vector PWM compare generator. One item (v_alpha, v_beta, bus_voltage) is taken
// on every clock where start is high; busy stays low, so an item may enter every cycle.
// Each result appears with done high for exactly one cycle. TIME_W is VOLT_WIDTH +
// TICK_WIDTH + 1 capped at 48. The restoring dividers resolve one quotient bit per stage:
// three divide by the bus voltage, two rescale t1 and t2 on overmodulation.
// Results come out in input order and cannot be held off. pwm_period is written over
// the cfg port (always ready) and must only change while no item is in flight.
module svpwm_compare_generator #(
  parameter int VOLT_WIDTH = 16,
  parameter int TICK_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VOLT_WIDTH-1:0] v_alpha,
  input  logic signed [VOLT_WIDTH-1:0] v_beta,
  input  logic [VOLT_WIDTH-1:0]        bus_voltage,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [TICK_WIDTH-1:0]        cfg_data,
  output logic                         done,
  output logic [TICK_WIDTH-1:0]        compare_a,
  output logic [TICK_WIDTH-1:0]        compare_b,
  output logic [TICK_WIDTH-1:0]        compare_c,
  output logic [2:0]                   sector_code,
  output logic                         over_modulated,
  output logic                         bus_fault
);
  import svpwm_pkg::*;

  localparam int QUO1_W = VOLT_WIDTH + TICK_WIDTH + 1;
  localparam int TIME_W = (QUO1_W > CAP_W) ? CAP_W : QUO1_W;
  localparam int QUO2_W = TIME_W + TICK_WIDTH;
  localparam int CTL_W  = $bits(svpwm_ctl_t);

  logic [TICK_WIDTH-1:0]   pwm_period;
  logic                    accept;

  logic                    f_valid;
  logic [QUO1_W-1:0]       f_num_x, f_num_y, f_num_z;
  logic [VOLT_WIDTH-1:0]   f_den;
  logic [2:0]              f_neg;
  svpwm_ctl_t              f_ctl;

  logic                    dx_valid, dy_valid, dz_valid;
  logic [QUO1_W-1:0]       dx_quo, dy_quo, dz_quo;
  logic [CTL_W:0]          dx_tag;
  logic                    dy_tag, dz_tag;

  logic                    m_valid;
  logic [QUO2_W-1:0]       m_num_1, m_num_2;
  logic [TIME_W:0]         m_den;
  logic signed [TIME_W:0]  m_t_1, m_t_2;
  logic [1:0]              m_neg;
  svpwm_ctl_t              m_ctl;

  logic                    d1_valid, d2_valid;
  logic [QUO2_W-1:0]       d1_quo, d2_quo;
  logic [TIME_W+1+CTL_W:0] d1_tag;
  logic [TIME_W+1:0]       d2_tag;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= TICK_WIDTH'(5000);
    end else if (cfg_valid && cfg_ready) begin
      pwm_period <= cfg_data;
    end
  end

  svpwm_front #(
    .VOLT_WIDTH (VOLT_WIDTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .v_alpha     (v_alpha),
    .v_beta      (v_beta),
    .bus_voltage (bus_voltage),
    .period      (pwm_period),
    .out_valid   (f_valid),
    .num_x       (f_num_x),
    .num_y       (f_num_y),
    .num_z       (f_num_z),
    .den         (f_den),
    .neg         (f_neg),
    .ctl         (f_ctl)
  );

  svpwm_div #(.NUM_W(QUO1_W), .DEN_W(VOLT_WIDTH), .TAG_W(CTL_W + 1)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num_x),
    .den       (f_den),
    .tag       ({f_neg[0], f_ctl}),
    .out_valid (dx_valid),
    .quo       (dx_quo),
    .out_tag   (dx_tag)
  );

  svpwm_div #(.NUM_W(QUO1_W), .DEN_W(VOLT_WIDTH), .TAG_W(1)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num_y),
    .den       (f_den),
    .tag       (f_neg[1]),
    .out_valid (dy_valid),
    .quo       (dy_quo),
    .out_tag   (dy_tag)
  );

  svpwm_div #(.NUM_W(QUO1_W), .DEN_W(VOLT_WIDTH), .TAG_W(1)) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num_z),
    .den       (f_den),
    .tag       (f_neg[2]),
    .out_valid (dz_valid),
    .quo       (dz_quo),
    .out_tag   (dz_tag)
  );

  svpwm_mid #(
    .QUO_W      (QUO1_W),
    .TIME_W     (TIME_W),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dx_valid && dy_valid && dz_valid),
    .q_x       (dx_quo),
    .q_y       (dy_quo),
    .q_z       (dz_quo),
    .neg       ({dz_tag, dy_tag, dx_tag[CTL_W]}),
    .ctl       (svpwm_ctl_t'(dx_tag[CTL_W-1:0])),
    .period    (pwm_period),
    .out_valid (m_valid),
    .num_1     (m_num_1),
    .num_2     (m_num_2),
    .den       (m_den),
    .t_1       (m_t_1),
    .t_2       (m_t_2),
    .neg_out   (m_neg),
    .ctl_out   (m_ctl)
  );

  svpwm_div #(.NUM_W(QUO2_W), .DEN_W(TIME_W + 1), .TAG_W(TIME_W + 2 + CTL_W)) u_div_1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .num       (m_num_1),
    .den       (m_den),
    .tag       ({m_t_1, m_neg[0], m_ctl}),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .out_tag   (d1_tag)
  );

  svpwm_div #(.NUM_W(QUO2_W), .DEN_W(TIME_W + 1), .TAG_W(TIME_W + 2)) u_div_2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .num       (m_num_2),
    .den       (m_den),
    .tag       ({m_t_2, m_neg[1]}),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .out_tag   (d2_tag)
  );

  svpwm_back #(
    .TIME_W     (TIME_W),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (d1_valid && d2_valid),
    .q_1            (d1_quo),
    .q_2            (d2_quo),
    .t_1            ($signed(d1_tag[TIME_W+1+CTL_W:CTL_W+1])),
    .t_2            ($signed(d2_tag[TIME_W+1:1])),
    .neg            ({d2_tag[0], d1_tag[CTL_W]}),
    .ctl            (svpwm_ctl_t'(d1_tag[CTL_W-1:0])),
    .period         (pwm_period),
    .out_valid      (done),
    .compare_a      (compare_a),
    .compare_b      (compare_b),
    .compare_c      (compare_c),
    .sector_code    (sector_code),
    .over_modulated (over_modulated),
    .bus_fault      (bus_fault)
  );

endmodule
`default_nettype wire

FILE: rtl/core/svpwm_checker.sv
`default_nettype none
module svpwm_checker #(
  parameter int TICK_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [TICK_WIDTH-1:0] cfg_data,
  input logic                  done,
  input logic [TICK_WIDTH-1:0] compare_a,
  input logic [TICK_WIDTH-1:0] compare_b,
  input logic [TICK_WIDTH-1:0] compare_c,
  input logic [2:0]            sector_code,
  input logic                  over_modulated,
  input logic                  bus_fault
);
  import svpwm_pkg::*;

  logic [TICK_WIDTH-1:0] period;
  logic [TICK_WIDTH-1:0] half;

  assign half = period >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= TICK_WIDTH'(5000);
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  a_fault_flat: assert property (@(posedge clk) disable iff (rst)
    done && bus_fault |-> !over_modulated && compare_a == compare_b && compare_b == compare_c)
    else $error("bus fault result not flat");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    done && (sector_code == SECTOR_NONE || sector_code == SECTOR_ALL)
    |-> !over_modulated && compare_a == compare_b && compare_b == compare_c)
    else $error("zero vector result not flat");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    done |-> compare_a <= half && compare_b <= half && compare_c <= half)
    else $error("compare value above half period");

endmodule

bind svpwm_compare_generator svpwm_checker #(.TICK_WIDTH(TICK_WIDTH)) u_svpwm_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_data       (cfg_data),
  .done           (done),
  .compare_a      (compare_a),
  .compare_b      (compare_b),
  .compare_c      (compare_c),
  .sector_code    (sector_code),
  .over_modulated (over_modulated),
  .bus_fault      (bus_fault)
);
`default_nettype wire
